>>> rtl/srts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package srts_pkg;

  // List size and field widths.
  localparam int MAX_TRACKS = 256;
  localparam int IDX_W      = 8;
  localparam int CNT_W      = 9;

  // Result status codes.
  localparam logic [1:0] ST_PLAY = 2'd0;
  localparam logic [1:0] ST_STOP = 2'd1;
  localparam logic [1:0] ST_ERR  = 2'd2;

  // Request codes.
  localparam logic [2:0] REQ_APPEND   = 3'd0;
  localparam logic [2:0] REQ_LOAD     = 3'd1;
  localparam logic [2:0] REQ_NEXT_END = 3'd2;
  localparam logic [2:0] REQ_NEXT_MAN = 3'd3;
  localparam logic [2:0] REQ_PREV     = 3'd4;
  localparam logic [2:0] REQ_SELECT   = 3'd5;
  localparam logic [2:0] REQ_STOP     = 3'd6;
  localparam logic [2:0] REQ_SHUFFLE  = 3'd7;

  // Configuration register indexes.
  localparam logic [1:0] CFG_REPEAT = 2'd0;
  localparam logic [1:0] CFG_SEED   = 2'd1;

  // Repeat modes.
  localparam logic [1:0] RPT_SINGLE = 2'd1;
  localparam logic [1:0] RPT_ALL    = 2'd2;

  // Galois LFSR feedback mask for x^32+x^22+x^2+x+1.
  localparam logic [31:0] LFSR_MASK = 32'h8020_0003;

  // Remainder unit: quotient bits resolved per cycle and cycles per operation.
  localparam int REM_DIGITS = 8;
  localparam int REM_CYCLES = 32 / REM_DIGITS;

  // One right-shifting step of the generator.
  function automatic logic [31:0] lfsr_next(input logic [31:0] x);
    lfsr_next = (x >> 1) ^ (x[0] ? LFSR_MASK : 32'd0);
  endfunction

endpackage

`default_nettype wire

>>> rtl/srts_rem.sv
`timescale 1ns / 1ps
`default_nettype none

// Restoring remainder of a 32-bit word by a 9-bit divisor, several bits a cycle.
module srts_rem (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [31:0] dividend_i,
  input  wire logic [8:0]  divisor_i,
  output logic             done_o,
  output logic [8:0]       rem_o
);

  localparam int CW = $clog2(srts_pkg::REM_CYCLES);

  logic          busy_q;
  logic          done_q;
  logic [CW-1:0] cnt_q;
  logic [31:0]   num_q, num_d;
  logic [8:0]    div_q;
  logic [8:0]    rem_q, rem_d;

  // Resolve a group of quotient bits against the divisor.
  always_comb begin
    logic [9:0] t;
    rem_d = rem_q;
    num_d = num_q;
    for (int k = 0; k < srts_pkg::REM_DIGITS; k++) begin
      t     = {rem_d, num_d[31]};
      num_d = num_d << 1;
      if (t >= {1'b0, div_q}) begin
        rem_d = 9'(t - {1'b0, div_q});
      end else begin
        rem_d = t[8:0];
      end
    end
  end

  // Control of the operation.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(srts_pkg::REM_CYCLES - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i;
      div_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= num_d;
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

>>> rtl/srts_hist.sv
`timescale 1ns / 1ps
`default_nettype none

// History ring storage: one write port and one registered read port.
module srts_hist #(
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [7:0]               wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [7:0]                    rdata_o
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/shuffle_repeat_track_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none

// Track sequencer with repeat modes and shuffled picks.
// A request transaction (req_type_i, req_value_i) is taken when start is high
// and busy is low. busy falls in the same cycle as the result is presented.
// Each result appears on the result ports for one cycle with done_o high;
// the receiver cannot stall, so results are never held back.
// Configuration writes (cfg_index_i, cfg_data_i) complete when cfg_valid_i and
// cfg_ready_o are both high; cfg_ready_o is high while the block is idle.
// Index 0 is the repeat mode, index 1 reloads the random generator.
// Append, load, select, stop, set shuffle and unshuffled next go from the
// execute state straight to done; previous with a history entry first reads
// the history ring. A shuffled next scans all entries with one shared
// remainder unit: a skipped entry is passed over in the scan state, and each
// unvisited candidate steps the generator and waits for its remainder.
// With repeat all a second pass runs only when the first found no candidate.
// Reset empties the list, clears current, last played, visited and history,
// clears shuffle and repeat, and loads the generator with 1.
module shuffle_repeat_track_sequencer #(
  parameter int HIST_DEPTH = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  req_type_i,
  input  wire logic [8:0]  req_value_i,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  output logic             done_o,
  output logic [1:0]       status_o,
  output logic [7:0]       track_index_o,
  output logic signed [8:0] current_now_o,
  output logic [8:0]       entry_total_o,
  output logic             shuffle_now_o
);

  localparam int HW = $clog2(HIST_DEPTH);
  localparam int FW = $clog2(HIST_DEPTH + 1);
  localparam int MT = srts_pkg::MAX_TRACKS;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_RWAIT = 3'd3;
  localparam logic [2:0] S_PEND  = 3'd4;
  localparam logic [2:0] S_PRDA  = 3'd5;
  localparam logic [2:0] S_PFIN  = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0]    state_q, state_d;
  logic [2:0]    req_q;
  logic [8:0]    val_q;
  logic [1:0]    rmode_q, rmode_d;
  logic [31:0]   rnd_q, rnd_d;
  logic [8:0]    count_q, count_d;
  logic [8:0]    cur_q, cur_d;
  logic [8:0]    last_q, last_d;
  logic          shuf_q, shuf_d;
  logic [MT-1:0] vis_q, vis_d;
  logic [FW-1:0] fill_q, fill_d;
  logic [HW-1:0] top_q, top_d;
  logic [1:0]    stat_q, stat_d;
  logic [7:0]    idx_q, idx_d;
  logic [8:0]    i_q, i_d;
  logic [8:0]    seen_q, seen_d;
  logic          found_q, found_d;
  logic [7:0]    chosen_q, chosen_d;
  logic          pass2_q, pass2_d;
  logic          out_vld_q;
  logic [1:0]    out_stat_q;
  logic [7:0]    out_idx_q;
  logic [8:0]    out_cur_q;
  logic [8:0]    out_cnt_q;
  logic          out_shuf_q;

  logic          accept;
  logic          cfg_we;
  logic          rem_start;
  logic [31:0]   rem_dividend;
  logic          rem_done;
  logic [8:0]    rem_val;
  logic          hist_we;
  logic [7:0]    hist_rdata;
  logic          cur_valid;
  logic          last_valid;
  logic [HW-1:0] top_inc;
  logic [HW-1:0] top_dec;
  logic [FW-1:0] fill_inc;

  assign busy        = (state_q != S_IDLE);
  assign accept      = start && !busy;
  assign cfg_ready_o = !busy;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  assign cur_valid  = !cur_q[8] && ({1'b0, cur_q[7:0]} < count_q);
  assign last_valid = !last_q[8] && ({1'b0, last_q[7:0]} < count_q);
  assign top_inc    = (top_q == HW'(HIST_DEPTH - 1)) ? '0 : HW'(top_q + 1'b1);
  assign top_dec    = (top_q == '0) ? HW'(HIST_DEPTH - 1) : HW'(top_q - 1'b1);
  assign fill_inc   = (fill_q < FW'(HIST_DEPTH)) ? FW'(fill_q + 1'b1) : fill_q;

  // Sequencer and state update.
  always_comb begin
    state_d      = state_q;
    rmode_d      = rmode_q;
    rnd_d        = rnd_q;
    count_d      = count_q;
    cur_d        = cur_q;
    last_d       = last_q;
    shuf_d       = shuf_q;
    vis_d        = vis_q;
    fill_d       = fill_q;
    top_d        = top_q;
    stat_d       = stat_q;
    idx_d        = idx_q;
    i_d          = i_q;
    seen_d       = seen_q;
    found_d      = found_q;
    chosen_d     = chosen_q;
    pass2_d      = pass2_q;
    rem_start    = 1'b0;
    rem_dividend = srts_pkg::lfsr_next(rnd_q);
    hist_we      = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        stat_d  = srts_pkg::ST_PLAY;
        idx_d   = '0;
        state_d = S_DONE;
        unique case (req_q)
          srts_pkg::REQ_APPEND: begin
            if (count_q >= 9'(MT)) begin
              stat_d = srts_pkg::ST_ERR;
            end else begin
              idx_d                = count_q[7:0];
              vis_d[count_q[7:0]]  = 1'b0;
              count_d              = count_q + 1'b1;
              if (cur_q[8]) begin
                cur_d    = '0;
                vis_d[0] = 1'b1;
              end
            end
          end
          srts_pkg::REQ_LOAD: begin
            if (val_q > 9'(MT)) begin
              stat_d = srts_pkg::ST_ERR;
            end else begin
              count_d = val_q;
              cur_d   = '1;
              last_d  = '1;
              vis_d   = '0;
              fill_d  = '0;
            end
          end
          srts_pkg::REQ_NEXT_END, srts_pkg::REQ_NEXT_MAN: begin
            if (count_q == '0) begin
              stat_d = srts_pkg::ST_STOP;
            end else if (!cur_valid) begin
              stat_d = srts_pkg::ST_ERR;
            end else if (req_q == srts_pkg::REQ_NEXT_END &&
                         rmode_q == srts_pkg::RPT_SINGLE) begin
              idx_d = cur_q[7:0];
            end else if (!shuf_q) begin
              if (({1'b0, cur_q[7:0]} + 9'd1) < count_q) begin
                hist_we = 1'b1;
                top_d   = top_inc;
                fill_d  = fill_inc;
                idx_d   = 8'(cur_q[7:0] + 1'b1);
              end else if (rmode_q == srts_pkg::RPT_ALL) begin
                hist_we = 1'b1;
                top_d   = top_inc;
                fill_d  = fill_inc;
              end else begin
                stat_d = srts_pkg::ST_STOP;
              end
            end else begin
              // Shuffled pick: mark the current entry and scan the list.
              vis_d[cur_q[7:0]] = 1'b1;
              i_d               = '0;
              seen_d            = '0;
              found_d           = 1'b0;
              pass2_d           = 1'b0;
              state_d           = S_SCAN;
            end
          end
          srts_pkg::REQ_PREV: begin
            if (count_q == '0) begin
              stat_d = srts_pkg::ST_STOP;
            end else if (cur_q[8]) begin
              if (last_valid) begin
                idx_d = last_q[7:0];
                if (shuf_q && fill_q == '0) begin
                  vis_d              = '0;
                  vis_d[last_q[7:0]] = 1'b1;
                end
              end else begin
                stat_d = srts_pkg::ST_STOP;
              end
            end else if (!cur_valid) begin
              stat_d = srts_pkg::ST_ERR;
            end else if (fill_q != '0) begin
              top_d   = top_dec;
              fill_d  = FW'(fill_q - 1'b1);
              state_d = S_PRDA;
            end else if (!shuf_q && cur_q[7:0] != '0) begin
              idx_d = 8'(cur_q[7:0] - 1'b1);
            end else begin
              stat_d = srts_pkg::ST_STOP;
            end
          end
          srts_pkg::REQ_SELECT: begin
            if (val_q >= count_q) begin
              stat_d = srts_pkg::ST_ERR;
            end else begin
              cur_d             = val_q;
              last_d            = val_q;
              vis_d[val_q[7:0]] = 1'b1;
              idx_d             = val_q[7:0];
            end
          end
          srts_pkg::REQ_STOP: begin
            if (cur_valid) begin
              last_d = cur_q;
            end
            cur_d  = '1;
            stat_d = srts_pkg::ST_STOP;
          end
          srts_pkg::REQ_SHUFFLE: begin
            shuf_d = (val_q != '0);
            fill_d = '0;
            vis_d  = '0;
            if (cur_valid) begin
              vis_d[cur_q[7:0]] = 1'b1;
            end
          end
          default: begin
            stat_d = srts_pkg::ST_ERR;
          end
        endcase
      end

      S_SCAN: begin
        if (i_q >= count_q) begin
          state_d = S_PEND;
        end else if (!vis_q[i_q[7:0]] && !(count_q > 9'd1 && i_q == cur_q)) begin
          // Candidate: step the generator and reduce modulo the running count.
          seen_d    = seen_q + 1'b1;
          rnd_d     = srts_pkg::lfsr_next(rnd_q);
          rem_start = 1'b1;
          state_d   = S_RWAIT;
        end else begin
          i_d = i_q + 1'b1;
        end
      end

      S_RWAIT: begin
        if (rem_done) begin
          if (rem_val == '0) begin
            found_d  = 1'b1;
            chosen_d = i_q[7:0];
          end
          i_d     = i_q + 1'b1;
          state_d = S_SCAN;
        end
      end

      S_PEND: begin
        state_d = S_DONE;
        if (found_q) begin
          hist_we = 1'b1;
          top_d   = top_inc;
          fill_d  = fill_inc;
          idx_d   = chosen_q;
        end else if (rmode_q == srts_pkg::RPT_ALL && !pass2_q) begin
          // Everything visited: start a fresh round and pick again.
          vis_d             = '0;
          vis_d[cur_q[7:0]] = 1'b1;
          pass2_d           = 1'b1;
          i_d               = '0;
          seen_d            = '0;
          state_d           = S_SCAN;
        end else if (rmode_q == srts_pkg::RPT_ALL) begin
          idx_d = cur_q[7:0];
        end else begin
          stat_d = srts_pkg::ST_STOP;
        end
      end

      S_PRDA: begin
        state_d = S_PFIN;
      end

      S_PFIN: begin
        idx_d = hist_rdata;
        if (shuf_q && fill_q == '0) begin
          vis_d             = '0;
          vis_d[hist_rdata] = 1'b1;
        end
        state_d = S_DONE;
      end

      S_DONE: begin
        state_d = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Configuration writes arrive only while idle.
    if (cfg_we) begin
      if (cfg_index_i == srts_pkg::CFG_REPEAT) begin
        rmode_d = cfg_data_i[1:0];
      end else if (cfg_index_i == srts_pkg::CFG_SEED) begin
        rnd_d = (cfg_data_i != '0) ? cfg_data_i : 32'd1;
      end
    end
  end

  // Control and list state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      rmode_q   <= '0;
      rnd_q     <= 32'd1;
      count_q   <= '0;
      cur_q     <= '1;
      last_q    <= '1;
      shuf_q    <= 1'b0;
      vis_q     <= '0;
      fill_q    <= '0;
      top_q     <= '0;
      out_vld_q <= 1'b0;
      i_q       <= '0;
      seen_q    <= '0;
      found_q   <= 1'b0;
      pass2_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      rmode_q   <= rmode_d;
      rnd_q     <= rnd_d;
      count_q   <= count_d;
      cur_q     <= cur_d;
      last_q    <= last_d;
      shuf_q    <= shuf_d;
      vis_q     <= vis_d;
      fill_q    <= fill_d;
      top_q     <= top_d;
      out_vld_q <= (state_q == S_DONE);
      i_q       <= i_d;
      seen_q    <= seen_d;
      found_q   <= found_d;
      pass2_q   <= pass2_d;
    end
  end

  // Request capture, work values and result registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_type_i;
      val_q <= req_value_i;
    end
    stat_q   <= stat_d;
    idx_q    <= idx_d;
    chosen_q <= chosen_d;
    if (state_q == S_DONE) begin
      out_stat_q <= stat_q;
      out_idx_q  <= (stat_q == srts_pkg::ST_PLAY) ? idx_q : '0;
      out_cur_q  <= cur_q;
      out_cnt_q  <= count_q;
      out_shuf_q <= shuf_q;
    end
  end

  srts_rem u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rem_start),
    .dividend_i (rem_dividend),
    .divisor_i  (seen_d),
    .done_o     (rem_done),
    .rem_o      (rem_val)
  );

  srts_hist #(
    .DEPTH (HIST_DEPTH)
  ) u_hist (
    .clk_i   (clk_i),
    .we_i    (hist_we),
    .waddr_i (top_q),
    .wdata_i (cur_q[7:0]),
    .raddr_i (top_q),
    .rdata_o (hist_rdata)
  );

  assign done_o        = out_vld_q;
  assign status_o      = out_stat_q;
  assign track_index_o = out_idx_q;
  assign current_now_o = out_cur_q;
  assign entry_total_o = out_cnt_q;
  assign shuffle_now_o = out_shuf_q;

endmodule

`default_nettype wire

>>> sim/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int HIST_DEPTH  = 64;
  localparam int CYCLE_LIMIT = 10000000;

  typedef enum logic {ITEM_REQ, ITEM_CFG} item_kind_e;

  typedef struct {
    item_kind_e  kind;
    logic [2:0]  req;
    logic [31:0] value;
    int          gap;
  } pending_t;

  typedef struct {
    logic [1:0] status;
    logic [7:0] track;
    logic [8:0] current;
    logic [8:0] total;
    logic       shuffle;
  } outcome_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  req_type_i = '0;
  logic [8:0]  req_value_i = '0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic        done_o;
  logic [1:0]  status_o;
  logic [7:0]  track_index_o;
  logic signed [8:0] current_now_o;
  logic [8:0]  entry_total_o;
  logic        shuffle_now_o;

  pending_t pending_q[$];
  outcome_t outcome_q[$];
  int       errors = 0;
  int       quiet = 0;
  int       cycles = 0;
  bit       no_idle = 0;

  // Shadow state of the sequencer.
  int          list_len;
  int          cur_entry;
  int          last_entry;
  bit          shuffle_on;
  bit          visited[srts_pkg::MAX_TRACKS];
  logic [7:0]  hist_ring[HIST_DEPTH];
  int          hist_fill;
  int          hist_top;
  logic [31:0] rand_word;
  logic [1:0]  repeat_sel;

  shuffle_repeat_track_sequencer dut (
    .clk_i, .rst_ni, .start, .busy, .req_type_i, .req_value_i,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .done_o, .status_o, .track_index_o, .current_now_o,
    .entry_total_o, .shuffle_now_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic bit cur_ok();
    return cur_entry >= 0 && cur_entry < list_len;
  endfunction

  function automatic void mark_cur();
    if (cur_ok()) visited[cur_entry] = 1'b1;
  endfunction

  function automatic void clear_seen();
    foreach (visited[i]) visited[i] = 1'b0;
  endfunction

  function automatic void push_hist(int idx);
    if (idx < 0) return;
    hist_ring[hist_top] = idx[7:0];
    hist_top = (hist_top + 1) % HIST_DEPTH;
    if (hist_fill < HIST_DEPTH) hist_fill++;
  endfunction

  // Reservoir draw over unvisited entries, skipping current in lists above one.
  function automatic int draw_unvisited();
    int chosen;
    int seen;
    chosen = -1;
    seen = 0;
    for (int i = 0; i < list_len; i++) begin
      if (visited[i]) continue;
      if (list_len > 1 && i == cur_entry) continue;
      seen++;
      rand_word = (rand_word >> 1) ^ (rand_word[0] ? srts_pkg::LFSR_MASK : 32'd0);
      if (rand_word % seen == 0) chosen = i;
    end
    return chosen;
  endfunction

  function automatic logic [1:0] next_entry(bit at_end, output int idx);
    int nx;
    idx = 0;
    if (list_len == 0) return srts_pkg::ST_STOP;
    if (!cur_ok()) return srts_pkg::ST_ERR;
    if (at_end && repeat_sel == srts_pkg::RPT_SINGLE) begin
      idx = cur_entry;
      return srts_pkg::ST_PLAY;
    end
    if (!shuffle_on) begin
      if (cur_entry + 1 < list_len) begin
        push_hist(cur_entry);
        idx = cur_entry + 1;
        return srts_pkg::ST_PLAY;
      end
      if (repeat_sel == srts_pkg::RPT_ALL) begin
        push_hist(cur_entry);
        return srts_pkg::ST_PLAY;
      end
      return srts_pkg::ST_STOP;
    end
    mark_cur();
    nx = draw_unvisited();
    if (nx < 0 && repeat_sel == srts_pkg::RPT_ALL) begin
      clear_seen();
      mark_cur();
      nx = draw_unvisited();
      if (nx < 0) begin
        idx = cur_entry;
        return srts_pkg::ST_PLAY;
      end
    end
    if (nx >= 0) begin
      push_hist(cur_entry);
      idx = nx;
      return srts_pkg::ST_PLAY;
    end
    return srts_pkg::ST_STOP;
  endfunction

  function automatic logic [1:0] prev_entry(output int idx);
    idx = 0;
    if (list_len == 0) return srts_pkg::ST_STOP;
    if (cur_entry < 0) begin
      if (last_entry >= 0 && last_entry < list_len) begin
        idx = last_entry;
        if (shuffle_on && hist_fill == 0) begin
          clear_seen();
          visited[idx] = 1'b1;
        end
        return srts_pkg::ST_PLAY;
      end
      return srts_pkg::ST_STOP;
    end
    if (cur_entry >= list_len) return srts_pkg::ST_ERR;
    if (hist_fill > 0) begin
      hist_top = (hist_top + HIST_DEPTH - 1) % HIST_DEPTH;
      hist_fill--;
      idx = hist_ring[hist_top];
      if (shuffle_on && hist_fill == 0) begin
        clear_seen();
        visited[idx] = 1'b1;
      end
      return srts_pkg::ST_PLAY;
    end
    if (!shuffle_on && cur_entry > 0) begin
      idx = cur_entry - 1;
      return srts_pkg::ST_PLAY;
    end
    return srts_pkg::ST_STOP;
  endfunction

  // Computes the result of one request transaction and updates the shadow state.
  function automatic outcome_t sequence_request(logic [2:0] req, logic [8:0] val);
    outcome_t o;
    int idx;
    logic [1:0] st;
    st = srts_pkg::ST_PLAY;
    idx = 0;
    case (req)
      srts_pkg::REQ_APPEND: begin
        if (list_len >= srts_pkg::MAX_TRACKS) st = srts_pkg::ST_ERR;
        else begin
          idx = list_len;
          visited[idx] = 1'b0;
          list_len++;
          if (cur_entry < 0) begin
            cur_entry = 0;
            mark_cur();
          end
        end
      end
      srts_pkg::REQ_LOAD: begin
        if (val > srts_pkg::MAX_TRACKS) st = srts_pkg::ST_ERR;
        else begin
          list_len = val;
          cur_entry = -1;
          last_entry = -1;
          clear_seen();
          hist_fill = 0;
        end
      end
      srts_pkg::REQ_NEXT_END, srts_pkg::REQ_NEXT_MAN:
        st = next_entry(req == srts_pkg::REQ_NEXT_END, idx);
      srts_pkg::REQ_PREV: st = prev_entry(idx);
      srts_pkg::REQ_SELECT: begin
        if (val >= list_len) st = srts_pkg::ST_ERR;
        else begin
          cur_entry = val;
          last_entry = val;
          mark_cur();
          idx = val;
        end
      end
      srts_pkg::REQ_STOP: begin
        if (cur_ok()) last_entry = cur_entry;
        cur_entry = -1;
        st = srts_pkg::ST_STOP;
      end
      default: begin
        shuffle_on = (val != 0);
        hist_fill = 0;
        clear_seen();
        mark_cur();
      end
    endcase
    if (st != srts_pkg::ST_PLAY) idx = 0;
    o.status = st;
    o.track = idx[7:0];
    o.current = cur_entry[8:0];
    o.total = list_len[8:0];
    o.shuffle = shuffle_on;
    return o;
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic add_req(logic [2:0] req, logic [8:0] val);
    pending_q.push_back('{ITEM_REQ, req, {23'd0, val}, pick_gap()});
  endtask

  task automatic add_cfg(logic [1:0] idx, logic [31:0] data);
    pending_q.push_back('{ITEM_CFG, {1'b0, idx}, data, pick_gap()});
  endtask

  // Accepted transactions: predict on requests, track config writes.
  always @(posedge clk_i) begin
    if (rst_ni && pending_q.size() > 0) begin
      if (start && !busy) begin
        outcome_q.push_back(sequence_request(req_type_i, req_value_i));
        void'(pending_q.pop_front());
      end else if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == srts_pkg::CFG_REPEAT) repeat_sel = cfg_data_i[1:0];
        else if (cfg_index_i == srts_pkg::CFG_SEED)
          rand_word = (cfg_data_i == 0) ? 32'd1 : cfg_data_i;
        void'(pending_q.pop_front());
      end
    end
    quiet <= (busy || done_o) ? 0 : quiet + 1;
  end

  // Driver: presents the front of the pending queue after its gap.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (pending_q.size() == 0) begin
        start <= 1'b0;
        cfg_valid_i <= 1'b0;
      end else if (pending_q[0].gap > 0) begin
        pending_q[0].gap--;
        start <= 1'b0;
        cfg_valid_i <= 1'b0;
      end else if (pending_q[0].kind == ITEM_REQ) begin
        start <= 1'b1;
        cfg_valid_i <= 1'b0;
        req_type_i <= pending_q[0].req;
        req_value_i <= pending_q[0].value[8:0];
      end else begin
        start <= 1'b0;
        // Configuration only once the block has drained and settled.
        if (outcome_q.size() == 0 && quiet >= 8) begin
          cfg_valid_i <= 1'b1;
          cfg_index_i <= pending_q[0].req[1:0];
          cfg_data_i <= pending_q[0].value;
        end else begin
          cfg_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (outcome_q.size() == 0) begin
        $display("%0t: unexpected result status %0d track %0d", $time, status_o,
                 track_index_o);
        errors++;
      end else begin
        outcome_t e;
        e = outcome_q.pop_front();
        if (status_o !== e.status) begin
          $display("%0t: status expected %0d actual %0d", $time, e.status, status_o);
          errors++;
        end
        if (track_index_o !== e.track) begin
          $display("%0t: track_index expected %0d actual %0d", $time, e.track,
                   track_index_o);
          errors++;
        end
        if (current_now_o !== e.current) begin
          $display("%0t: current_now expected %0d actual %0d", $time,
                   $signed(e.current), current_now_o);
          errors++;
        end
        if (entry_total_o !== e.total) begin
          $display("%0t: entry_total expected %0d actual %0d", $time, e.total,
                   entry_total_o);
          errors++;
        end
        if (shuffle_now_o !== e.shuffle) begin
          $display("%0t: shuffle_now expected %0d actual %0d", $time, e.shuffle,
                   shuffle_now_o);
          errors++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int n;
    int r;
    list_len = 0;
    cur_entry = -1;
    last_entry = -1;
    shuffle_on = 1'b0;
    clear_seen();
    hist_fill = 0;
    hist_top = 0;
    rand_word = 32'd1;
    repeat_sel = 2'd0;

    // Directed opening: edges of every request and of the registers.
    add_req(srts_pkg::REQ_NEXT_END, 9'd0);
    add_req(srts_pkg::REQ_PREV, 9'd0);
    add_req(srts_pkg::REQ_APPEND, 9'd0);
    add_req(srts_pkg::REQ_NEXT_MAN, 9'd0);
    add_req(srts_pkg::REQ_LOAD, 9'd257);
    add_req(srts_pkg::REQ_LOAD, 9'd256);
    add_req(srts_pkg::REQ_APPEND, 9'h1FF);
    add_req(srts_pkg::REQ_NEXT_END, 9'd0);
    add_req(srts_pkg::REQ_SELECT, 9'd256);
    add_req(srts_pkg::REQ_SELECT, 9'd255);
    add_req(srts_pkg::REQ_NEXT_END, 9'd0);
    add_req(srts_pkg::REQ_PREV, 9'd0);
    add_req(srts_pkg::REQ_STOP, 9'd0);
    add_req(srts_pkg::REQ_PREV, 9'd0);
    add_cfg(srts_pkg::CFG_SEED, 32'd0);
    add_cfg(srts_pkg::CFG_REPEAT, 32'd3);
    add_req(srts_pkg::REQ_LOAD, 9'd3);
    add_req(srts_pkg::REQ_SHUFFLE, 9'h100);
    add_req(srts_pkg::REQ_APPEND, 9'd0);
    add_req(srts_pkg::REQ_NEXT_MAN, 9'd0);
    add_req(srts_pkg::REQ_SELECT, 9'd1);
    add_req(srts_pkg::REQ_NEXT_END, 9'd0);
    add_req(srts_pkg::REQ_NEXT_END, 9'd0);
    add_req(srts_pkg::REQ_NEXT_END, 9'd0);
    add_cfg(srts_pkg::CFG_SEED, 32'hFFFF_FFFF);
    add_cfg(srts_pkg::CFG_REPEAT, 32'(srts_pkg::RPT_ALL));
    add_req(srts_pkg::REQ_NEXT_MAN, 9'd0);
    add_req(srts_pkg::REQ_NEXT_MAN, 9'd0);
    add_req(srts_pkg::REQ_PREV, 9'd0);
    add_req(srts_pkg::REQ_SHUFFLE, 9'd0);

    // Random phases: a fresh setting, a list, then mostly navigation.
    for (int ph = 0; ph < 14; ph++) begin
      no_idle = (ph % 5 == 2);
      add_cfg(srts_pkg::CFG_REPEAT, $urandom_range(0, 3));
      r = $urandom_range(0, 5);
      add_cfg(srts_pkg::CFG_SEED, r == 0 ? 32'd0 : r == 1 ? 32'hFFFF_FFFF : $urandom());
      n = (ph % 7 == 6) ? 256 : $urandom_range(0, 12);
      add_req(srts_pkg::REQ_LOAD, 9'(n));
      add_req(srts_pkg::REQ_SHUFFLE,
              9'($urandom_range(0, 1) ? $urandom_range(1, 511) : 0));
      add_req(srts_pkg::REQ_APPEND, 9'($urandom()));
      add_req(srts_pkg::REQ_SELECT, 9'($urandom_range(0, n)));
      for (int k = 0; k < 65; k++) begin
        r = $urandom_range(0, 99);
        if (r < 45)
          add_req($urandom_range(0, 1) ? srts_pkg::REQ_NEXT_END : srts_pkg::REQ_NEXT_MAN,
                  9'($urandom()));
        else if (r < 65) add_req(srts_pkg::REQ_PREV, 9'($urandom()));
        else if (r < 75)
          add_req(srts_pkg::REQ_SELECT,
                  9'($urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, n)));
        else if (r < 80) add_req(srts_pkg::REQ_STOP, 9'($urandom()));
        else if (r < 88)
          add_req(srts_pkg::REQ_SHUFFLE, 9'($urandom_range(0, 1) ? $urandom() : 0));
        else if (r < 97) add_req(srts_pkg::REQ_APPEND, 9'($urandom()));
        else
          add_req(srts_pkg::REQ_LOAD,
                  9'($urandom_range(0, 1) ? $urandom_range(0, 12) : $urandom()));
      end
    end

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    wait (pending_q.size() == 0 && outcome_q.size() == 0);
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/srts_pkg.sv
rtl/srts_rem.sv
rtl/srts_hist.sv
rtl/shuffle_repeat_track_sequencer.sv
sim/testbench.sv
